// File: src/vector3_normalize_macros.svh
// Assertion macros shared by the checker
`ifndef VECTOR3_NORMALIZE_MACROS_SVH
`define VECTOR3_NORMALIZE_MACROS_SVH

// Clocked check, masked while reset is held
`define VN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds across reset
`define VN_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/vn_pkg.sv
package vn_pkg;

    localparam int COMPONENT_WIDTH_DEF      = 16;
    localparam int RESULT_FRACTION_BITS_DEF = 14;
    localparam int OUT_WIDTH                = RESULT_FRACTION_BITS_DEF + 2;

    typedef struct packed {
        logic signed [COMPONENT_WIDTH_DEF-1:0] in_x;
        logic signed [COMPONENT_WIDTH_DEF-1:0] in_y;
        logic signed [COMPONENT_WIDTH_DEF-1:0] in_z;
    } t_vec_in;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] unit_x;
        logic signed [OUT_WIDTH-1:0] unit_y;
        logic signed [OUT_WIDTH-1:0] unit_z;
        logic                        zero_length;
    } t_vec_out;

    // Control that travels alongside each word through the pipeline
    typedef struct packed {
        logic       valid;
        logic [2:0] neg;
        logic       zero;
    } t_ctrl;

endpackage

// File: src/vn_front.sv
module vn_front #(
    parameter int CW = vn_pkg::COMPONENT_WIDTH_DEF,
    parameter int F  = vn_pkg::RESULT_FRACTION_BITS_DEF,
    localparam int SW = 2*CW + 2,
    localparam int PW = 2*CW + 2*F + 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  vn_pkg::t_vec_in i_vec,
    output vn_pkg::t_ctrl   o_ctrl,
    output logic [SW-1:0]   o_s,
    output logic [PW-1:0]   o_r [3]
);

    logic [CW-1:0]   w_raw [3];
    vn_pkg::t_ctrl   r_c1, r_c2, r_c3;
    logic [CW-1:0]   r_mag [3];
    logic [2*CW-1:0] r_sq  [3];
    logic [SW-1:0]   w_sum;
    logic [SW-1:0]   r_s;
    logic [PW-1:0]   r_r [3];

    assign w_raw[0] = CW'(i_vec.in_x);
    assign w_raw[1] = CW'(i_vec.in_y);
    assign w_raw[2] = CW'(i_vec.in_z);

    assign w_sum = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.valid <= 1'b0;
            r_c2.valid <= 1'b0;
            r_c3.valid <= 1'b0;
        end else if (i_en) begin
            r_c1.valid <= i_valid;
            r_c2.valid <= r_c1.valid;
            r_c3.valid <= r_c2.valid;
        end
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_c1.neg[l] <= w_raw[l][CW-1];
                // the most negative value keeps its exact magnitude in CW bits
                r_mag[l]    <= w_raw[l][CW-1] ? (CW'(0) - w_raw[l]) : w_raw[l];
                r_sq[l]     <= r_mag[l] * r_mag[l];
                r_r[l]      <= PW'(r_sq[l]) << (2*F);
            end
            r_c1.zero <= 1'b0;
            r_c2.neg  <= r_c1.neg;
            r_c2.zero <= 1'b0;
            r_c3.neg  <= r_c2.neg;
            r_c3.zero <= (w_sum == '0);
            r_s       <= w_sum;
        end
    end

    assign o_ctrl = r_c3;
    assign o_s    = r_s;
    assign o_r    = r_r;

endmodule

// File: src/vn_root_stage.sv
module vn_root_stage #(
    parameter int CW     = vn_pkg::COMPONENT_WIDTH_DEF,
    parameter int F      = vn_pkg::RESULT_FRACTION_BITS_DEF,
    parameter int BITPOS = 0,
    localparam int SW = 2*CW + 2,
    localparam int PW = 2*CW + 2*F + 4,
    localparam int QW = F + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  vn_pkg::t_ctrl i_ctrl,
    input  logic [SW-1:0] i_s,
    input  logic [PW-1:0] i_r  [3],
    input  logic [QW-1:0] i_q  [3],
    input  logic [PW-1:0] i_p  [3],
    input  logic [PW-1:0] i_qs [3],
    output vn_pkg::t_ctrl o_ctrl,
    output logic [SW-1:0] o_s,
    output logic [PW-1:0] o_r  [3],
    output logic [QW-1:0] o_q  [3],
    output logic [PW-1:0] o_p  [3],
    output logic [PW-1:0] o_qs [3]
);

    // (q + 2^b)^2 * S = q^2*S + (q*S) << (b+1) + S << 2b
    logic [PW-1:0] w_cand [3];
    logic [2:0]    w_take;
    vn_pkg::t_ctrl r_ctrl;
    logic [SW-1:0] r_s;
    logic [PW-1:0] r_r  [3];
    logic [QW-1:0] r_q  [3];
    logic [PW-1:0] r_p  [3];
    logic [PW-1:0] r_qs [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_cand[l] = i_p[l] + (i_qs[l] << (BITPOS + 1)) + (PW'(i_s) << (2*BITPOS));
            w_take[l] = (w_cand[l] <= i_r[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctrl.valid <= i_ctrl.valid;
        end
        if (i_en) begin
            r_ctrl.neg  <= i_ctrl.neg;
            r_ctrl.zero <= i_ctrl.zero;
            r_s         <= i_s;
            for (int l = 0; l < 3; l++) begin
                r_r[l] <= i_r[l];
                if (w_take[l]) begin
                    r_q[l]  <= i_q[l] | (QW'(1) << BITPOS);
                    r_p[l]  <= w_cand[l];
                    r_qs[l] <= i_qs[l] + (PW'(i_s) << BITPOS);
                end else begin
                    r_q[l]  <= i_q[l];
                    r_p[l]  <= i_p[l];
                    r_qs[l] <= i_qs[l];
                end
            end
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_s    = r_s;
    assign o_r    = r_r;
    assign o_q    = r_q;
    assign o_p    = r_p;
    assign o_qs   = r_qs;

endmodule

// File: src/vn_back.sv
module vn_back #(
    parameter int F = vn_pkg::RESULT_FRACTION_BITS_DEF,
    localparam int QW = F + 1,
    localparam int OW = F + 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  vn_pkg::t_ctrl    i_ctrl,
    input  logic [QW-1:0]    i_q [3],
    output logic             o_valid,
    output vn_pkg::t_vec_out o_res
);

    localparam logic [QW-1:0] ONE = QW'(1) << F;

    logic [QW-1:0]    w_sat [3];
    logic [OW-1:0]    w_val [3];
    logic             r_valid;
    vn_pkg::t_vec_out r_res;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_sat[l] = (i_q[l] > ONE) ? ONE : i_q[l];
            if (i_ctrl.zero) begin
                w_val[l] = '0;
            end else if (i_ctrl.neg[l]) begin
                w_val[l] = OW'(0) - OW'(w_sat[l]);
            end else begin
                w_val[l] = OW'(w_sat[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.unit_x      <= vn_pkg::OUT_WIDTH'(signed'(w_val[0]));
            r_res.unit_y      <= vn_pkg::OUT_WIDTH'(signed'(w_val[1]));
            r_res.unit_z      <= vn_pkg::OUT_WIDTH'(signed'(w_val[2]));
            r_res.zero_length <= i_ctrl.zero;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: src/vector3_normalize.sv
// Scales each 3D vector to unit length: unit_c = c / sqrt(x^2+y^2+z^2), Q1.14, truncated
// toward zero. A fully pipelined unit: one vector enters every cycle while o_stall is low,
// and its word passes through three front stages (magnitude, square, sum), one root stage
// per result bit that settles that bit of all three components by an exact shift-and-add
// compare, and an output register. A zero vector yields zeros with zero_length set.
// o_stall follows i_stall while a word waits at the output; the whole pipeline then holds.
module vector3_normalize (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  vn_pkg::t_vec_in  i_vec,
    output logic             o_stall,
    output logic             o_valid,
    output vn_pkg::t_vec_out o_res,
    input  logic             i_stall
);

    localparam int CW = vn_pkg::COMPONENT_WIDTH_DEF;
    localparam int F  = vn_pkg::RESULT_FRACTION_BITS_DEF;
    localparam int SW = 2*CW + 2;
    localparam int PW = 2*CW + 2*F + 4;
    localparam int QW = F + 1;
    localparam int NS = F + 1;

    logic          w_en;
    vn_pkg::t_ctrl w_ctrl [NS+1];
    logic [SW-1:0] w_s    [NS+1];
    logic [PW-1:0] w_r    [NS+1][3];
    logic [QW-1:0] w_q    [NS+1][3];
    logic [PW-1:0] w_p    [NS+1][3];
    logic [PW-1:0] w_qs   [NS+1][3];

    // hold everything while the output word is refused
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    vn_front #(.CW(CW), .F(F)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_vec   (i_vec),
        .o_ctrl  (w_ctrl[0]),
        .o_s     (w_s[0]),
        .o_r     (w_r[0])
    );

    assign w_q[0]  = '{default: '0};
    assign w_p[0]  = '{default: '0};
    assign w_qs[0] = '{default: '0};

    for (genvar k = 0; k < NS; k++) begin : g_root
        vn_root_stage #(.CW(CW), .F(F), .BITPOS(F - k)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctrl  (w_ctrl[k]),
            .i_s     (w_s[k]),
            .i_r     (w_r[k]),
            .i_q     (w_q[k]),
            .i_p     (w_p[k]),
            .i_qs    (w_qs[k]),
            .o_ctrl  (w_ctrl[k+1]),
            .o_s     (w_s[k+1]),
            .o_r     (w_r[k+1]),
            .o_q     (w_q[k+1]),
            .o_p     (w_p[k+1]),
            .o_qs    (w_qs[k+1])
        );
    end

    vn_back #(.F(F)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctrl  (w_ctrl[NS]),
        .i_q     (w_q[NS]),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule

// File: src/vn_checker.sv
`include "vector3_normalize_macros.svh"

module vn_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input vn_pkg::t_vec_in  i_vec,
    input logic             o_stall,
    input logic             o_valid,
    input vn_pkg::t_vec_out o_res,
    input logic             i_stall
);

    `VN_ASSERT(a_hold_word, o_valid && i_stall |=> o_valid && $stable(o_res), "word changed under stall")
    `VN_ASSERT(a_zero_out, o_valid && o_res.zero_length |-> o_res.unit_x == '0 && o_res.unit_y == '0 && o_res.unit_z == '0, "zero vector gave nonzero word")
    `VN_ASSERT(a_range_x, o_valid |-> $signed(o_res.unit_x) <= 16384 && $signed(o_res.unit_x) >= -16384, "unit_x out of range")
    `VN_ASSERT(a_stall_cause, o_stall |-> o_valid && i_stall, "stall without a refused word")
    `VN_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_valid, "word after reset")

endmodule

bind vector3_normalize vn_checker u_vn_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CW   = vn_pkg::COMPONENT_WIDTH_DEF;
    localparam int FB   = vn_pkg::RESULT_FRACTION_BITS_DEF;
    localparam int OW   = vn_pkg::OUT_WIDTH;
    localparam int LAT  = FB + 5;
    localparam int WDOG = 2000;
    localparam int N_RANDOM = 1550;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    vn_pkg::t_vec_in  i_vec = '0;
    logic             o_stall;
    logic             o_valid;
    vn_pkg::t_vec_out o_res;
    logic             i_stall = 1'b0;

    vector3_normalize u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_vec   (i_vec),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_res   (o_res),
        .i_stall (i_stall)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    vn_pkg::t_vec_out unit_q[$];
    vn_pkg::t_vec_out pend_q[$];
    int               n_err = 0;
    int               idle_cnt = 0;
    bit               calm = 1'b0;
    bit               drive_done = 1'b0;

    // floor(m * 2^F / sqrt(s)) found bit by bit with exact compares
    function automatic logic [FB:0] unit_mag(logic [CW:0] m, logic [2*CW+1:0] s);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [FB:0]  q;
        logic [FB:0]  t;
        q   = '0;
        rhs = 128'(m) * 128'(m) << (2 * FB);
        for (int b = FB; b >= 0; b--) begin
            t   = q | (FB+1)'(1) << b;
            lhs = 128'(t) * 128'(t) * 128'(s);
            if (lhs <= rhs) q = t;
        end
        if (q > (FB+1)'(1) << FB) q = (FB+1)'(1) << FB;
        return q;
    endfunction

    function automatic vn_pkg::t_vec_out normalise(vn_pkg::t_vec_in v);
        vn_pkg::t_vec_out r;
        logic [CW-1:0]    c[3];
        logic [CW:0]      m[3];
        logic [FB:0]      q[3];
        logic [OW-1:0]    u[3];
        logic [2*CW+1:0]  s;
        c = '{v.in_x, v.in_y, v.in_z};
        s = '0;
        for (int i = 0; i < 3; i++) begin
            m[i] = c[i][CW-1] ? (CW+1)'(0) - {1'b1, c[i]} : {1'b0, c[i]};
            s    = s + (2*CW+2)'(m[i]) * (2*CW+2)'(m[i]);
        end
        r = '0;
        if (s == 0) begin
            r.zero_length = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            q[i] = unit_mag(m[i], s);
            // widen before negating so the sign reaches the top bit
            u[i] = c[i][CW-1] ? OW'(0) - OW'(q[i]) : OW'(q[i]);
        end
        r.unit_x = u[0];
        r.unit_y = u[1];
        r.unit_z = u[2];
        return r;
    endfunction

    // Directed vectors; rows flagged known carry a result read off by hand
    typedef struct {
        vn_pkg::t_vec_in  v;
        bit               known;
        vn_pkg::t_vec_out r;
    } t_row;

    localparam logic [CW-1:0] MAXP = 16'sh7fff;
    localparam logic [CW-1:0] MAXN = 16'sh8000;
    localparam logic [OW-1:0] ONE  = 16'sd16384;
    localparam logic [OW-1:0] MONE = -16'sd16384;

    t_row rows[] = '{
        '{'{16'd0, 16'd0, 16'd0},  1, '{16'd0, 16'd0, 16'd0, 1'b1}},
        '{'{MAXP, 16'd0, 16'd0},   1, '{ONE, 16'd0, 16'd0, 1'b0}},
        '{'{16'd0, MAXP, 16'd0},   1, '{16'd0, ONE, 16'd0, 1'b0}},
        '{'{16'd0, 16'd0, MAXP},   1, '{16'd0, 16'd0, ONE, 1'b0}},
        '{'{MAXN, 16'd0, 16'd0},   1, '{MONE, 16'd0, 16'd0, 1'b0}},
        '{'{16'd0, MAXN, 16'd0},   1, '{16'd0, MONE, 16'd0, 1'b0}},
        '{'{16'd0, 16'd0, MAXN},   1, '{16'd0, 16'd0, MONE, 1'b0}},
        '{'{16'd1, 16'd0, 16'd0},  1, '{ONE, 16'd0, 16'd0, 1'b0}},
        '{'{16'hffff, 16'd0, 16'd0}, 1, '{MONE, 16'd0, 16'd0, 1'b0}},
        '{'{MAXP, MAXP, MAXP},     0, '0},
        '{'{MAXN, MAXN, MAXN},     0, '0},
        '{'{MAXN, MAXP, MAXN},     0, '0},
        '{'{MAXP, MAXN, 16'd1},    0, '0},
        '{'{16'd1, 16'd1, 16'd1},  0, '0},
        '{'{16'd1, 16'hffff, 16'd0}, 0, '0},
        '{'{16'd4096, 16'd4096, 16'd0}, 0, '0},
        '{'{16'd3, 16'd4, 16'd0},  0, '0},
        '{'{16'd1, 16'd2, 16'd2},  0, '0},
        '{'{16'h5555, 16'haaaa, 16'h5555}, 0, '0},
        '{'{16'haaaa, 16'h5555, 16'haaaa}, 0, '0},
        '{'{16'd0, 16'd1, MAXN},   0, '0}
    };

    function automatic vn_pkg::t_vec_in random_vec();
        vn_pkg::t_vec_in v;
        logic [CW-1:0]   c[3];
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 9))
                0:       c[i] = '0;
                1:       c[i] = $urandom_range(0, 1) ? MAXP : MAXN;
                2:       c[i] = CW'($urandom_range(0, 15)) - 16'd8;
                default: c[i] = CW'($urandom);
            endcase
        end
        v.in_x = c[0];
        v.in_y = c[1];
        v.in_z = c[2];
        return v;
    endfunction

    // Hold the word until accepted, idling at random outside the calm stretch
    task automatic send_word(vn_pkg::t_vec_in v);
        if (!calm) begin
            while ($urandom_range(0, 99) < 27) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_vec   <= v;
        do @(posedge i_clk); while (o_stall);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 27);
        end
    end

    // Score each output word against the oldest expectation
    always @(posedge i_clk) begin
        vn_pkg::t_vec_out exp_w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (unit_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected word %h", o_res);
            end else begin
                exp_w = unit_q.pop_front();
                if (o_res !== exp_w) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp %0d %0d %0d %0b act %0d %0d %0d %0b",
                            $signed(exp_w.unit_x), $signed(exp_w.unit_y),
                            $signed(exp_w.unit_z), exp_w.zero_length,
                            $signed(o_res.unit_x), $signed(o_res.unit_y),
                            $signed(o_res.unit_z), o_res.zero_length);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || drive_done)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG) begin
            $display("vector3_normalize test failed");
            $finish;
        end
    end

    // Enqueue expectations on acceptance so the queue follows the handshake
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) unit_q.push_back(pend_q.pop_front());
    end

    task automatic push_word(vn_pkg::t_vec_in v, vn_pkg::t_vec_out r);
        pend_q.push_back(r);
        send_word(v);
    endtask

    initial begin
        vn_pkg::t_vec_in v;
        int              waited;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[k]) begin
            push_word(rows[k].v, rows[k].known ? rows[k].r : normalise(rows[k].v));
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            calm = (k >= 600 && k < 800);
            v = random_vec();
            push_word(v, normalise(v));
        end
        calm = 1'b0;
        i_valid <= 1'b0;
        waited = 0;
        while ((unit_q.size() != 0 || pend_q.size() != 0) && waited < 100 * WDOG) begin
            @(posedge i_clk);
            waited++;
        end
        drive_done = 1'b1;
        repeat (2 * LAT) @(posedge i_clk);
        if (n_err == 0 && unit_q.size() == 0)
            $display("vector3_normalize test passed");
        else
            $display("vector3_normalize test failed");
        $finish;
    end
endmodule

// File: files.f
+incdir+src
src/vn_pkg.sv
src/vn_front.sv
src/vn_root_stage.sv
src/vn_back.sv
src/vector3_normalize.sv
src/vn_checker.sv
tb/tb.sv
